@@ src/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_t;

  typedef struct packed {
    logic    load;
    logic    shift_in;
    logic    shift_out;
    logic    show_head;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

@@ src/spq_if.sv @@
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if #(
  parameter int VALUE_WIDTH = 16,
  parameter int PRIO_WIDTH  = 8
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [VALUE_WIDTH-1:0] item_value;
  logic [PRIO_WIDTH-1:0]  item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if #(
  parameter int VALUE_WIDTH = 16,
  parameter int PRIO_WIDTH  = 8,
  parameter int COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] head_value;
  logic [PRIO_WIDTH-1:0]  head_priority;
  logic [1:0]             status;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, head_value, head_priority, status, entry_count, input ready);
  modport sink   (input valid, head_value, head_priority, status, entry_count, output ready);
endinterface

@@ src/spq_ctrl.sv @@
// Handshake controller and operation decoder of the sorted priority queue.
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic [1:0]     opcode,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    req_ready     = (state == spq_pkg::S_IDLE) || rsp_ready;
    rsp_valid     = (state == spq_pkg::S_HOLD);
    accept        = req_valid && req_ready;
    cmd           = '0;
    cmd.status    = spq_pkg::ST_OK;
    cmd.load      = accept;
    state_next    = state;
    if (accept) begin
      state_next = spq_pkg::S_HOLD;
    end else if (rsp_ready) begin
      state_next = spq_pkg::S_IDLE;
    end
    case (spq_pkg::opcode_t'(opcode))
      spq_pkg::OP_ENQUEUE: begin
        if (stat.full) begin
          cmd.status = spq_pkg::ST_FULL;
        end else begin
          cmd.shift_in = accept;
        end
      end
      spq_pkg::OP_DEQUEUE: begin
        if (stat.empty) begin
          cmd.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.shift_out = accept;
          cmd.show_head = 1'b1;
        end
      end
      spq_pkg::OP_PEEK: begin
        if (stat.empty) begin
          cmd.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.show_head = 1'b1;
        end
      end
      default: begin
        cmd.status = spq_pkg::ST_OK;
      end
    endcase
  end

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_in |-> !stat.full) else $error("insert while full");
  a_no_remove_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_out |-> !stat.empty) else $error("remove while empty");
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp_valid) else $error("result not shown after accept");

endmodule

@@ src/spq_datapath.sv @@
// Compare-and-shift entry row, occupancy count and result register.
module spq_datapath #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int PRIO_WIDTH  = 8,
  parameter int COUNT_WIDTH = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  spq_pkg::cmd_t          cmd,
  output spq_pkg::stat_t         stat,
  input  logic [VALUE_WIDTH-1:0] item_value,
  input  logic [PRIO_WIDTH-1:0]  item_priority,
  output logic [VALUE_WIDTH-1:0] head_value,
  output logic [PRIO_WIDTH-1:0]  head_priority,
  output logic [1:0]             status,
  output logic [COUNT_WIDTH-1:0] entry_count
);

  logic [VALUE_WIDTH-1:0] vals  [DEPTH];
  logic [PRIO_WIDTH-1:0]  prios [DEPTH];
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [DEPTH-1:0]       gt;
  logic [DEPTH-1:0]       take_new;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (COUNT_WIDTH'(i) < count) && (prios[i] > item_priority);
    end
    take_new   = {gt[DEPTH-2:0], 1'b1};
    stat.empty = (count == '0);
    stat.full  = (count == COUNT_WIDTH'(DEPTH));
    count_next = count;
    if (cmd.shift_in) begin
      count_next = count + 1'b1;
    end else if (cmd.shift_out) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.shift_in && !gt[i]) begin
        if (take_new[i]) begin
          vals[i]  <= item_value;
          prios[i] <= item_priority;
        end else begin
          vals[i]  <= vals[(i == 0) ? 0 : i-1];
          prios[i] <= prios[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.shift_out && (i < DEPTH-1)) begin
        vals[i]  <= vals[(i < DEPTH-1) ? i+1 : i];
        prios[i] <= prios[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_value    <= cmd.show_head ? vals[0] : '0;
      head_priority <= cmd.show_head ? prios[0] : '0;
      status        <= cmd.status;
      entry_count   <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_WIDTH'(DEPTH)) else $error("count beyond depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_in |=> count == $past(count) + 1'b1) else $error("insert count");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_out |=> count == $past(count) - 1'b1) else $error("remove count");

endmodule

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller, entry row and channels.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; the compare-and-shift row finishes each
// operation in the accept cycle and a single result register holds it.
// A new item is taken when idle, or while the held result is taken in the same cycle.
// Reset clears the entry count and the handshake; row contents stay undefined.
module sorted_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int PRIO_WIDTH  = 8
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .opcode    (req.opcode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .PRIO_WIDTH  (PRIO_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_value    (req.item_value),
    .item_priority (req.item_priority),
    .head_value    (rsp.head_value),
    .head_priority (rsp.head_priority),
    .status        (rsp.status),
    .entry_count   (rsp.entry_count)
  );

endmodule

@@ tb/sv/tb_sorted_priority_queue.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue: directed and random items checked against a queue model.
module tb_sorted_priority_queue;

  localparam int DEPTH      = 16;
  localparam int VALUE_W    = 16;
  localparam int PRIO_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int HALF_CYCLE = 5;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS   = 200;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } head_result_t;

  logic clk = 1'b0;
  logic rst;

  spq_req_if #(.VALUE_WIDTH(VALUE_W), .PRIO_WIDTH(PRIO_W)) req_ch ();
  spq_rsp_if #(.VALUE_WIDTH(VALUE_W), .PRIO_WIDTH(PRIO_W), .COUNT_WIDTH(COUNT_W)) rsp_ch ();

  sorted_priority_queue #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_W),
    .PRIO_WIDTH (PRIO_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [VALUE_W-1:0] row_value [DEPTH];
  logic [PRIO_W-1:0]  row_prio  [DEPTH];
  int unsigned        row_count;

  head_result_t pending_heads[$];
  int  mismatches;
  int  results_seen;
  int  items_sent;
  bit  gaps_on;
  bit  stalls_on;

  always #HALF_CYCLE clk = ~clk;

  function automatic head_result_t apply_op(input logic [1:0] op,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [PRIO_W-1:0] prio);
    head_result_t res;
    int unsigned pos;
    res = '0;
    res.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_ENQUEUE) begin
      if (row_count >= DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < row_count && row_prio[pos] > prio) pos++;
        for (int i = row_count; i > pos; i--) begin
          row_value[i] = row_value[i-1];
          row_prio[i]  = row_prio[i-1];
        end
        row_value[pos] = value;
        row_prio[pos]  = prio;
        row_count++;
      end
    end else if (op == spq_pkg::OP_DEQUEUE || op == spq_pkg::OP_PEEK) begin
      if (row_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.value = row_value[0];
        res.prio  = row_prio[0];
        if (op == spq_pkg::OP_DEQUEUE) begin
          for (int i = 0; i + 1 < row_count; i++) begin
            row_value[i] = row_value[i+1];
            row_prio[i]  = row_prio[i+1];
          end
          row_count--;
        end
      end
    end
    res.count = row_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 60)
      $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    head_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        pending_heads.push_back(apply_op(req_ch.opcode, req_ch.item_value, req_ch.item_priority));
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (pending_heads.size() == 0) begin
          report_mismatch("unexpected result, status", rsp_ch.status, 0);
        end else begin
          want = pending_heads.pop_front();
          if (rsp_ch.head_value !== want.value)
            report_mismatch("head_value", rsp_ch.head_value, want.value);
          if (rsp_ch.head_priority !== want.prio)
            report_mismatch("head_priority", rsp_ch.head_priority, want.prio);
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.entry_count !== want.count)
            report_mismatch("entry_count", rsp_ch.entry_count, want.count);
        end
      end
    end
  end

  always begin
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 6) == 0) begin
      rsp_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    rsp_ch.ready <= 1'b1;
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sorted_priority_queue: mismatch");
    $finish;
  end

  task automatic send_op(input logic [1:0] op, input logic [VALUE_W-1:0] value,
                         input logic [PRIO_W-1:0] prio);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.item_value    <= value;
    req_ch.item_priority <= prio;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_heads.size() != 0);
  endtask

  task automatic test_empty_reads();
    send_op(spq_pkg::OP_DEQUEUE, 16'hFFFF, 8'hFF);
    send_op(spq_pkg::OP_PEEK, 16'h0000, 8'h00);
    send_op(OP_UNUSED, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_fill_and_overflow();
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: prio = 8'hFF;
        1: prio = 8'h00;
        2: prio = 8'h80;
        default: prio = 8'h7F;
      endcase
      value = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : VALUE_W'($urandom);
      send_op(spq_pkg::OP_ENQUEUE, value, prio);
    end
    send_op(spq_pkg::OP_ENQUEUE, 16'hA5A5, 8'hFF);
    send_op(OP_UNUSED, 16'h5A5A, 8'h01);
    send_op(spq_pkg::OP_PEEK, 16'h0000, 8'h00);
    send_op(spq_pkg::OP_DEQUEUE, 16'h0000, 8'h00);
  endtask

  task automatic test_drain_pause();
    wait_results_drained();
  endtask

  task automatic random_item(input int enq_pct, input bit tie_heavy);
    int r;
    logic [1:0] op;
    logic [PRIO_W-1:0] prio;
    r = $urandom_range(0, 99);
    if (r < 3)
      op = OP_UNUSED;
    else if (r < 15)
      op = spq_pkg::OP_PEEK;
    else if ($urandom_range(0, 99) < enq_pct)
      op = spq_pkg::OP_ENQUEUE;
    else
      op = spq_pkg::OP_DEQUEUE;
    case ($urandom_range(0, 9))
      0: prio = '0;
      1: prio = '1;
      default: prio = tie_heavy ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    endcase
    send_op(op, VALUE_W'($urandom), prio);
  endtask

  task automatic test_random_mix();
    int seg_len;
    int enq_pct;
    bit tie_heavy;
    int segment;
    segment = 0;
    while (items_sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      tie_heavy = ($urandom_range(0, 2) == 0);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < seg_len; i++) random_item(enq_pct, tie_heavy);
      segment++;
      if (segment % 12 == 0) wait_results_drained();
    end
  endtask

  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < CALM_ITEMS; i++) random_item((i / 25) % 2 ? 30 : 75, i % 3 == 0);
  endtask

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = spq_pkg::OP_ENQUEUE;
    req_ch.item_value    = '0;
    req_ch.item_priority = '0;
    row_count    = 0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_reads();
    test_fill_and_overflow();
    test_drain_pause();
    test_random_mix();
    test_drain_pause();
    test_back_to_back();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("sorted_priority_queue: match");
    else
      $display("sorted_priority_queue: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
src/spq_pkg.sv
src/spq_if.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
